// ===== rtl/core/b2rd_pkg.sv =====
// Shared constants and digit encoding for the binary to radix digit converter.
`timescale 1ns / 1ps

package b2rd_pkg;

    localparam int VALUE_BITS_DEF = 32;   // default significant input width
    localparam int IN_W           = 32;   // input value port width
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;    // one digit value, 0..15
    localparam int CHAR_W         = 7;
    localparam int CHUNK_BITS     = 8;    // dividend bits consumed per divide cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end else begin
            e = r;
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/binary_to_radix_digits_unit.sv =====
// Binary to radix 2..16 ASCII digit converter, top level.
//
// Usage: write the radix through i_cfg_we / i_cfg_data while the unit is idle
// (values below 2 act as 2, above 16 act as 16; reset value is 10). Present a
// value on i_value with i_start; it is taken when o_busy is low. The digits
// come out most significant first, one digit per o_valid strobe cycle, on
// o_digit_char, with o_last on the final digit. Zero gives a single '0'.
//
// Timing: each digit is produced by one remainder pass of a shared divide unit
// that consumes 8 dividend bits per cycle. All divide passes run first, then
// the digits are popped from the digit stack. o_busy stays high over the whole
// item; the next start is taken in the cycle after the last digit has been
// registered.
//
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_valid and sets the radix to 10. The receiver cannot stall: every strobe
// is a delivered digit.
`timescale 1ns / 1ps

module binary_to_radix_digits_unit
    import b2rd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RADIX_W-1:0] i_cfg_data,
    input  logic               i_start,
    input  logic [IN_W-1:0]    i_value,
    output logic               o_busy,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last
);

    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WORK_W = NCHUNK * CHUNK_BITS;
    localparam int EXT_W  = (WORK_W > IN_W) ? WORK_W : IN_W;
    localparam int CHW    = $clog2(NCHUNK + 1);
    localparam int CNTW   = $clog2(VALUE_BITS + 1);
    localparam int DEPTH  = VALUE_BITS;   // radix 2 gives the most digits

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [RADIX_W-1:0] r_radix;      // config register, raw
    logic [RADIX_W-1:0] r_radix_eff;  // clamped copy latched per item
    logic [WORK_W-1:0]  r_work;
    logic [WORK_W-1:0]  n_work;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] n_rem;
    logic [CHW-1:0]     r_chunk;
    logic [CNTW-1:0]    r_count;
    logic [DIGIT_W-1:0] r_stack [DEPTH];
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [EXT_W-1:0]   w_ext;
    logic [WORK_W-1:0]  w_init;
    logic               w_accept;
    logic               w_last_chunk;

    assign w_accept     = i_start && (r_state == ST_IDLE);
    assign w_ext        = EXT_W'(i_value);
    assign w_init       = WORK_W'(w_ext[VALUE_BITS-1:0]);
    assign w_last_chunk = (r_chunk == CHW'(NCHUNK - 1));

    // Shared divide step: long division of the top chunk by the radix.
    // Remainder stays below the radix, so the trial value fits in 5 bits.
    always_comb begin
        logic [DIGIT_W-1:0]    rem;
        logic [DIGIT_W:0]      trial;
        logic [CHUNK_BITS-1:0] qbits;
        logic [CHUNK_BITS-1:0] chunk;
        chunk = r_work[WORK_W-1 -: CHUNK_BITS];
        rem   = r_rem;
        qbits = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            trial = {rem, chunk[i]};
            if (trial >= (DIGIT_W+1)'(r_radix_eff)) begin
                trial    = trial - (DIGIT_W+1)'(r_radix_eff);
                qbits[i] = 1'b1;
            end
            rem = trial[DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = WORK_W'({r_work, qbits});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_radix <= RADIX_RESET;
            r_valid <= 1'b0;
            r_chunk <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_DIV;
                        r_chunk <= '0;
                        r_count <= '0;
                    end
                end
                ST_DIV: begin
                    if (w_last_chunk) begin
                        r_chunk <= '0;
                        r_count <= r_count + 1'b1;
                        if (n_work == '0) begin
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_count <= r_count - 1'b1;
                    if (r_count == CNTW'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: work register, remainder, digit stack (LIFO), output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_radix_eff <= clamp_radix(r_radix);
            r_work      <= w_init;
            r_rem       <= '0;
        end else if (r_state == ST_DIV) begin
            r_work <= n_work;
            if (w_last_chunk) begin
                r_rem      <= '0;
                r_stack[0] <= n_rem;
                for (int i = 1; i < DEPTH; i++) begin
                    r_stack[i] <= r_stack[i-1];
                end
            end else begin
                r_rem <= n_rem;
            end
        end else if (r_state == ST_EMIT) begin
            r_char <= digit_ascii(r_stack[0]);
            r_last <= (r_count == CNTW'(1));
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_valid && r_last;

    // Each strobe comes from an emit cycle.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("digit strobe without emit cycle");

    // An accepted start makes the unit busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("start accepted but unit not busy");

    // Digit count never exceeds the stack depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("digit count overflow");

    // Emit phase always has a digit left to send.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("emit with empty digit stack");

    // Divide works with a clamped radix.
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_radix_eff >= RADIX_MIN && r_radix_eff <= RADIX_MAX))
        else $error("radix out of range during divide");

endmodule
